>>> design/oile_pkg.sv
// Shared constants, codes and controller/datapath interface types for the list engine.
package oile_pkg;

	// Fixed field widths
	localparam int CMD_W   = 3;
	localparam int POS_W   = 6;
	localparam int DATA_W  = 32;
	localparam int IDX_W   = 6;
	localparam int CNTO_W  = 7;

	// Stream word widths (fields packed from bit 0, padded to bytes)
	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 56;
	localparam int M_TUSER_W = 1;

	// Parameter defaults
	localparam int DEF_MAX_ENTRIES = 64;
	localparam int DEF_ITEM_WIDTH  = 32;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SORTED = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_GET    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SET    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_FIND   = 3'd6;

	// Datapath operation codes
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
	localparam logic [OP_W-1:0] OP_SCAN_INIT = 4'd2;
	localparam logic [OP_W-1:0] OP_SCAN      = 4'd3;
	localparam logic [OP_W-1:0] OP_UP_INIT   = 4'd4;
	localparam logic [OP_W-1:0] OP_UP        = 4'd5;
	localparam logic [OP_W-1:0] OP_DN_INIT   = 4'd6;
	localparam logic [OP_W-1:0] OP_DN        = 4'd7;
	localparam logic [OP_W-1:0] OP_CMP_INIT  = 4'd8;
	localparam logic [OP_W-1:0] OP_CMP       = 4'd9;
	localparam logic [OP_W-1:0] OP_CMP_END   = 4'd10;
	localparam logic [OP_W-1:0] OP_GET       = 4'd11;
	localparam logic [OP_W-1:0] OP_SET       = 4'd12;
	localparam logic [OP_W-1:0] OP_PUT       = 4'd13;
	localparam logic [OP_W-1:0] OP_SHRINK    = 4'd14;
	localparam logic [OP_W-1:0] OP_FINISH    = 4'd15;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            ok;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             full;
		logic             pos_le;
		logic             pos_lt;
		logic             walk_done;
		logic             scan_hit;
		logic             out_busy;
	} dp_stat_t;

endpackage

>>> design/oile_dp.sv
// Datapath: entry memory, walk pointers, entry count and result register.
module oile_dp
	import oile_pkg::*;
#(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int ITEM_WIDTH  = DEF_ITEM_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	input  logic [CMD_W-1:0]  in_command,
	input  logic [POS_W-1:0]  in_position,
	input  logic [DATA_W-1:0] in_item,
	input  logic [DATA_W-1:0] in_lookup,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              out_ok,
	output logic [IDX_W-1:0]  out_index,
	output logic [DATA_W-1:0] out_read,
	output logic [CNTO_W-1:0] out_removed,
	output logic [CNTO_W-1:0] out_count
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	logic [ITEM_WIDTH-1:0] mem [MAX_ENTRIES];
	logic [ITEM_WIDTH-1:0] rdata_q;

	logic [CMD_W-1:0]      cmd_q;
	logic [POS_W-1:0]      pos_q;
	logic [ITEM_WIDTH-1:0] val_q;
	logic [ITEM_WIDTH-1:0] look_q;
	logic [CW-1:0]         p_q;
	logic [CW-1:0]         w_q;
	logic [CW-1:0]         k_q;
	logic                  chk_q;
	logic [CW-1:0]         ins_q;
	logic [CW-1:0]         rem_q;
	logic [CW-1:0]         cnt_q;
	logic                  out_valid_q;

	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [ITEM_WIDTH-1:0] wr_data;
	logic                  step;
	logic                  eq_val;
	logic                  hit_cond;

	assign step     = (k_q != '0);
	assign eq_val   = (val_q == rdata_q);
	assign hit_cond = (cmd_q == CMD_FIND) ? (look_q == rdata_q) : (val_q <= rdata_q);

	assign stat.cmd       = cmd_q;
	assign stat.full      = (cnt_q >= CW'(MAX_ENTRIES));
	assign stat.pos_le    = (PW'(pos_q) <= PW'(cnt_q));
	assign stat.pos_lt    = (PW'(pos_q) < PW'(cnt_q));
	assign stat.walk_done = !step && !chk_q;
	assign stat.scan_hit  = chk_q && hit_cond;
	assign stat.out_busy  = out_valid_q && !out_ready;

	// Memory port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = p_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = w_q[AW-1:0];
		wr_data = rdata_q;
		unique case (cmd.op) inside
			OP_SCAN: rd_en = step;
			OP_UP, OP_DN: begin
				rd_en = step;
				wr_en = chk_q;
			end
			OP_CMP: begin
				rd_en = step;
				wr_en = chk_q && !eq_val;
			end
			OP_GET: begin
				rd_en   = 1'b1;
				rd_addr = ins_q[AW-1:0];
			end
			OP_SET, OP_PUT: begin
				wr_en   = 1'b1;
				wr_addr = ins_q[AW-1:0];
				wr_data = val_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Latched item payload
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			pos_q  <= in_position;
			val_q  <= ITEM_WIDTH'(in_item);
			look_q <= ITEM_WIDTH'(in_lookup);
		end
	end

	// Walk control and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= '0;
			p_q   <= '0;
			w_q   <= '0;
			k_q   <= '0;
			chk_q <= 1'b0;
			ins_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
		end else begin
			unique case (cmd.op) inside
				OP_LOAD: begin
					cmd_q <= in_command;
					ins_q <= CW'(in_position);
				end
				OP_SCAN_INIT: begin
					p_q   <= '0;
					k_q   <= cnt_q;
					chk_q <= 1'b0;
					ins_q <= cnt_q;
				end
				OP_SCAN: begin
					chk_q <= step;
					if (step) begin
						p_q <= p_q + 1'b1;
						k_q <= k_q - 1'b1;
					end
					if (chk_q && hit_cond) begin
						ins_q <= p_q - 1'b1;
					end
				end
				OP_UP_INIT: begin
					p_q   <= cnt_q - 1'b1;
					w_q   <= cnt_q;
					k_q   <= cnt_q - ins_q;
					chk_q <= 1'b0;
				end
				OP_UP: begin
					chk_q <= step;
					if (step) begin
						p_q <= p_q - 1'b1;
						k_q <= k_q - 1'b1;
					end
					if (chk_q) begin
						w_q <= w_q - 1'b1;
					end
				end
				OP_DN_INIT: begin
					p_q   <= ins_q + 1'b1;
					w_q   <= ins_q;
					k_q   <= cnt_q - ins_q - 1'b1;
					chk_q <= 1'b0;
				end
				OP_DN: begin
					chk_q <= step;
					if (step) begin
						p_q <= p_q + 1'b1;
						k_q <= k_q - 1'b1;
					end
					if (chk_q) begin
						w_q <= w_q + 1'b1;
					end
				end
				OP_CMP_INIT: begin
					p_q   <= '0;
					w_q   <= '0;
					k_q   <= cnt_q;
					chk_q <= 1'b0;
					rem_q <= '0;
				end
				OP_CMP: begin
					chk_q <= step;
					if (step) begin
						p_q <= p_q + 1'b1;
						k_q <= k_q - 1'b1;
					end
					if (chk_q) begin
						if (eq_val) begin
							rem_q <= rem_q + 1'b1;
						end else begin
							w_q <= w_q + 1'b1;
						end
					end
				end
				OP_CMP_END: cnt_q <= w_q;
				OP_PUT:     cnt_q <= cnt_q + 1'b1;
				OP_SHRINK:  cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_FINISH) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_FINISH) begin
			out_ok      <= cmd.ok;
			out_index   <= (cmd.ok && cmd_q != CMD_REMOVE) ? IDX_W'(ins_q) : '0;
			out_read    <= (cmd.ok && cmd_q == CMD_GET) ? DATA_W'(rdata_q) : '0;
			out_removed <= (cmd_q == CMD_REMOVE) ? CNTO_W'(rem_q) : '0;
			out_count   <= CNTO_W'(cnt_q);
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> design/oile_ctrl.sv
// Controller: sequences one command at a time through the datapath.
module oile_ctrl
	import oile_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_UPI    = 4'd3;
	localparam logic [3:0] S_UP     = 4'd4;
	localparam logic [3:0] S_DN     = 4'd5;
	localparam logic [3:0] S_CMP    = 4'd6;
	localparam logic [3:0] S_GET    = 4'd7;
	localparam logic [3:0] S_FINISH = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       ok_q;
	logic       ok_d;
	logic [OP_W-1:0] op;

	always_comb begin
		state_d = state_q;
		ok_d    = ok_q;
		op      = OP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				ok_d    = 1'b0;
				state_d = S_FINISH;
				unique case (stat.cmd)
					CMD_INSERT: begin
						if (!stat.full && stat.pos_le) state_d = S_UPI;
					end
					CMD_SORTED: begin
						if (!stat.full) begin
							op      = OP_SCAN_INIT;
							state_d = S_SCAN;
						end
					end
					CMD_ERASE: begin
						if (stat.pos_lt) begin
							op      = OP_DN_INIT;
							state_d = S_DN;
						end
					end
					CMD_REMOVE: begin
						op      = OP_CMP_INIT;
						state_d = S_CMP;
					end
					CMD_GET: begin
						if (stat.pos_lt) begin
							op      = OP_GET;
							state_d = S_GET;
						end
					end
					CMD_SET: begin
						if (stat.pos_lt) begin
							op   = OP_SET;
							ok_d = 1'b1;
						end
					end
					CMD_FIND: begin
						op      = OP_SCAN_INIT;
						state_d = S_SCAN;
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				op = OP_SCAN;
				if (stat.scan_hit || stat.walk_done) begin
					if (stat.cmd == CMD_FIND) begin
						ok_d    = stat.scan_hit;
						state_d = S_FINISH;
					end else begin
						state_d = S_UPI;
					end
				end
			end
			S_UPI: begin
				op      = OP_UP_INIT;
				state_d = S_UP;
			end
			S_UP: begin
				if (stat.walk_done) begin
					op      = OP_PUT;
					ok_d    = 1'b1;
					state_d = S_FINISH;
				end else begin
					op = OP_UP;
				end
			end
			S_DN: begin
				if (stat.walk_done) begin
					op      = OP_SHRINK;
					ok_d    = 1'b1;
					state_d = S_FINISH;
				end else begin
					op = OP_DN;
				end
			end
			S_CMP: begin
				if (stat.walk_done) begin
					op      = OP_CMP_END;
					ok_d    = 1'b1;
					state_d = S_FINISH;
				end else begin
					op = OP_CMP;
				end
			end
			S_GET: begin
				ok_d    = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!stat.out_busy) begin
					op      = OP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ok_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign cmd.op   = op;
	assign cmd.ok   = ok_q;

endmodule

>>> design/ordered_item_list_engine.sv
// Top level of the ordered item list engine: stream ports, controller and datapath.
//
//  Channel  | Signals                      | Carries
//  ---------+------------------------------+---------------------------------------------
//  s (in)   | s_tvalid s_tready s_tdata    | one command item: tuser = command,
//           | s_tuser                      | tdata = position, item_value, lookup_value
//  m (out)  | m_tvalid m_tready m_tdata    | one result item per command: tuser = ok,
//           | m_tuser                      | tdata = index, read_value, removed_count, count
//
// Commands are taken one at a time, and every walk steps through one entry a cycle using the
// single read and write port of the memory.
// Reset clears the entry count; the memory itself holds no reset value.
// A stalled result waits in the output register and the next item is still taken, but the
// controller holds that item's result until the register drains.
module ordered_item_list_engine
	import oile_pkg::*;
#(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int ITEM_WIDTH  = DEF_ITEM_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // position, item_value, lookup_value
	input  logic [S_TUSER_W-1:0] s_tuser,  // command
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // index, read_value, removed_count, item_count
	output logic [M_TUSER_W-1:0] m_tuser   // ok
);

	localparam int POS_LO  = 0;
	localparam int ITEM_LO = POS_LO + POS_W;
	localparam int LOOK_LO = ITEM_LO + DATA_W;

	localparam int IDX_LO  = 0;
	localparam int READ_LO = IDX_LO + IDX_W;
	localparam int REM_LO  = READ_LO + DATA_W;
	localparam int CNT_LO  = REM_LO + CNTO_W;
	localparam int OUT_USED = CNT_LO + CNTO_W;

	dp_cmd_t  ctl_cmd;
	dp_stat_t dp_stat;

	logic              res_ok;
	logic [IDX_W-1:0]  res_index;
	logic [DATA_W-1:0] res_read;
	logic [CNTO_W-1:0] res_removed;
	logic [CNTO_W-1:0] res_count;

	// Sequence each command; the controller sees only the input handshake and datapath status.
	oile_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (dp_stat),
		.cmd      (ctl_cmd)
	);

	// Hold the entries and the result register.
	oile_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.ITEM_WIDTH  (ITEM_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (ctl_cmd),
		.stat        (dp_stat),
		.in_command  (s_tuser[CMD_W-1:0]),
		.in_position (s_tdata[POS_LO +: POS_W]),
		.in_item     (s_tdata[ITEM_LO +: DATA_W]),
		.in_lookup   (s_tdata[LOOK_LO +: DATA_W]),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_ok      (res_ok),
		.out_index   (res_index),
		.out_read    (res_read),
		.out_removed (res_removed),
		.out_count   (res_count)
	);

	// Pack the result item, lowest field first, zero pad to the byte boundary.
	assign m_tdata[IDX_LO +: IDX_W]               = res_index;
	assign m_tdata[READ_LO +: DATA_W]             = res_read;
	assign m_tdata[REM_LO +: CNTO_W]              = res_removed;
	assign m_tdata[CNT_LO +: CNTO_W]              = res_count;
	assign m_tdata[M_TDATA_W-1:OUT_USED]          = '0;
	assign m_tuser[0]                             = res_ok;

`ifndef SYNTHESIS
	// A taken item moves the controller out of idle at once.
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input still ready right after an item was taken");

	// A failed command reports no index, no read data and no removals.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |->
			(m_tdata[IDX_LO +: IDX_W] == '0) && (m_tdata[READ_LO +: DATA_W] == '0)
			&& (m_tdata[REM_LO +: CNTO_W] == '0))
		else $error("failed result carries nonzero fields");

	// An entry is placed only when there is room for it.
	a_put_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.op == OP_PUT |-> !dp_stat.full)
		else $error("entry placed into a full list");

	// A result is loaded only when the output register is free.
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.op == OP_FINISH |-> !(m_tvalid && !m_tready))
		else $error("result overwrote a stalled output item");
`endif

endmodule

>>> bench/ordered_item_list_engine_tb.sv
// Self-checking testbench for the ordered item list engine: directed table, random commands.
`timescale 1ns / 1ps

module ordered_item_list_engine_tb
	import oile_pkg::*;
();

	// No package name exists for the spare command code.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
	localparam int LIST_DEPTH   = DEF_MAX_ENTRIES;
	localparam int PHASE_ITEMS  = 232;
	localparam int PHASE_COUNT  = 8;
	// Longest command is a sorted insert into a list one short of full.
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] val;
		logic [DATA_W-1:0] look;
	} list_cmd_t;

	typedef struct packed {
		logic              ok;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] rd;
		logic [CNTO_W-1:0] rem;
		logic [CNTO_W-1:0] cnt;
	} list_result_t;

	typedef struct packed {
		list_cmd_t    item;
		logic         typed;
		list_result_t want;
	} table_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	// Mirror of the list contents, updated as each item is accepted.
	logic [DATA_W-1:0] entry_mirror [LIST_DEPTH];
	int                mirror_count = 0;
	list_result_t      pending_results [$];
	table_row_t        directed_rows [$];
	logic [DATA_W-1:0] value_pool [16];
	int                mismatch_count = 0;
	int                send_idle_pct = 0;
	int                recv_stall_pct = 0;

	ordered_item_list_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // position, item_value, lookup_value
		.s_tuser  (s_tuser),   // command
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // index, read_value, removed_count, item_count
		.m_tuser  (m_tuser)    // ok
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one command to the mirror and return the result it yields.
	function automatic list_result_t apply_list_command(list_cmd_t it);
		list_result_t r;
		int i;
		int kept;
		int slot;
		bit hit;
		r = '0;
		case (it.cmd) inside
			CMD_INSERT, CMD_SORTED: begin
				slot = it.pos;
				if (it.cmd == CMD_SORTED) begin
					// Place before the first entry that is not smaller.
					slot = mirror_count;
					hit = 1'b0;
					for (i = 0; i < mirror_count; i++) begin
						if (!hit && it.val <= entry_mirror[i]) begin
							slot = i;
							hit = 1'b1;
						end
					end
				end
				if (slot <= mirror_count && mirror_count < LIST_DEPTH) begin
					for (i = mirror_count; i > slot; i--)
						entry_mirror[i] = entry_mirror[i - 1];
					entry_mirror[slot] = it.val;
					mirror_count++;
					r.ok = 1'b1;
					r.idx = IDX_W'(slot);
				end
			end
			CMD_ERASE: begin
				if (it.pos < mirror_count) begin
					for (i = it.pos; i + 1 < mirror_count; i++)
						entry_mirror[i] = entry_mirror[i + 1];
					mirror_count--;
					r.ok = 1'b1;
					r.idx = it.pos;
				end
			end
			CMD_REMOVE: begin
				// Compact the survivors down and count the dropped ones.
				kept = 0;
				for (i = 0; i < mirror_count; i++) begin
					if (entry_mirror[i] == it.val)
						r.rem = r.rem + 1'b1;
					else begin
						entry_mirror[kept] = entry_mirror[i];
						kept++;
					end
				end
				mirror_count = kept;
				r.ok = 1'b1;
			end
			CMD_GET: begin
				if (it.pos < mirror_count) begin
					r.ok = 1'b1;
					r.idx = it.pos;
					r.rd = entry_mirror[it.pos];
				end
			end
			CMD_SET: begin
				if (it.pos < mirror_count) begin
					entry_mirror[it.pos] = it.val;
					r.ok = 1'b1;
					r.idx = it.pos;
				end
			end
			CMD_FIND: begin
				for (i = 0; i < mirror_count; i++) begin
					if (!r.ok && entry_mirror[i] == it.look) begin
						r.ok = 1'b1;
						r.idx = IDX_W'(i);
					end
				end
			end
			default: begin
			end
		endcase
		r.cnt = CNTO_W'(mirror_count);
		return r;
	endfunction

	task automatic add_row(input logic [CMD_W-1:0] cmd, input int pos,
			input logic [DATA_W-1:0] val, input logic [DATA_W-1:0] look,
			input bit typed, input bit ok, input int idx,
			input logic [DATA_W-1:0] rd, input int rem, input int cnt);
		table_row_t row;
		row.item = '{cmd: cmd, pos: POS_W'(pos), val: val, look: look};
		row.typed = typed;
		row.want = '{ok: ok, idx: IDX_W'(idx), rd: rd, rem: CNTO_W'(rem),
			cnt: CNTO_W'(cnt)};
		directed_rows.push_back(row);
	endtask

	// Drive one item, hold it until taken, then idle at random.
	task automatic issue_command(input list_cmd_t it, input bit typed,
			input list_result_t want);
		list_result_t r;
		s_tvalid <= 1'b1;
		s_tuser <= it.cmd;
		s_tdata <= {2'b00, it.look, it.val, it.pos};
		do
			@(posedge clk);
		while (!s_tready);
		r = apply_list_command(it);
		pending_results.push_back(typed ? want : r);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic list_cmd_t make_random_command(input bit grow);
		list_cmd_t it;
		int roll;
		roll = $urandom_range(99);
		if (grow)
			it.cmd = roll < 35 ? CMD_INSERT : roll < 60 ? CMD_SORTED :
				roll < 65 ? CMD_ERASE : roll < 68 ? CMD_REMOVE :
				roll < 76 ? CMD_GET : roll < 84 ? CMD_SET :
				roll < 96 ? CMD_FIND : CMD_UNUSED;
		else
			it.cmd = roll < 10 ? CMD_INSERT : roll < 20 ? CMD_SORTED :
				roll < 55 ? CMD_ERASE : roll < 62 ? CMD_REMOVE :
				roll < 72 ? CMD_GET : roll < 80 ? CMD_SET :
				roll < 95 ? CMD_FIND : CMD_UNUSED;
		// Mostly positions up to the count, some anywhere.
		if ($urandom_range(99) < 80 && mirror_count < LIST_DEPTH)
			it.pos = POS_W'($urandom_range(mirror_count));
		else
			it.pos = POS_W'($urandom_range(63));
		// Reuse a small pool so remove-all and find see duplicates.
		it.val = ($urandom_range(99) < 70) ? value_pool[$urandom_range(15)] : $urandom;
		if (mirror_count > 0 && $urandom_range(99) < 60)
			it.look = entry_mirror[$urandom_range(mirror_count - 1)];
		else
			it.look = ($urandom_range(1)) ? value_pool[$urandom_range(15)] : $urandom;
		return it;
	endfunction

	task automatic report_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		mismatch_count++;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
	endtask

	// Receiver: stall at random and check each taken result against the oldest one due.
	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			got.ok = m_tuser[0];
			got.idx = m_tdata[5:0];
			got.rd = m_tdata[37:6];
			got.rem = m_tdata[44:38];
			got.cnt = m_tdata[51:45];
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with none expected, actual %h", $time, got);
			end else begin
				want = pending_results.pop_front();
				if (got.ok !== want.ok)
					report_field("ok", DATA_W'(want.ok), DATA_W'(got.ok));
				if (got.idx !== want.idx)
					report_field("index", DATA_W'(want.idx), DATA_W'(got.idx));
				if (got.rd !== want.rd)
					report_field("read_value", want.rd, got.rd);
				if (got.rem !== want.rem)
					report_field("removed_count", DATA_W'(want.rem), DATA_W'(got.rem));
				if (got.cnt !== want.cnt)
					report_field("item_count", DATA_W'(want.cnt), DATA_W'(got.cnt));
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		#30_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		list_result_t none;
		int p;
		int n;
		none = '0;
		value_pool[0] = '0;
		value_pool[1] = '1;
		for (n = 2; n < 16; n++)
			value_pool[n] = $urandom;

		// Directed rows: empty list, extremes, rejected positions, spare code.
		add_row(CMD_GET,    0,  32'h0,        32'h0,        1, 0, 0, 0, 0, 0);
		add_row(CMD_ERASE,  0,  32'h0,        32'h0,        1, 0, 0, 0, 0, 0);
		add_row(CMD_INSERT, 1,  32'h7,        32'h0,        1, 0, 0, 0, 0, 0);
		add_row(CMD_FIND,   0,  32'h0,        32'h0,        1, 0, 0, 0, 0, 0);
		add_row(CMD_REMOVE, 0,  32'h5,        32'h0,        1, 1, 0, 0, 0, 0);
		add_row(CMD_INSERT, 0,  32'hFFFFFFFF, 32'h0,        1, 1, 0, 0, 0, 1);
		add_row(CMD_INSERT, 0,  32'h0,        32'h0,        1, 1, 0, 0, 0, 2);
		add_row(CMD_SORTED, 0,  32'h80000000, 32'h0,        0, 0, 0, 0, 0, 0);
		add_row(CMD_SORTED, 63, 32'h0,        32'h0,        0, 0, 0, 0, 0, 0);
		add_row(CMD_INSERT, 4,  32'h12345678, 32'h0,        0, 0, 0, 0, 0, 0);
		add_row(CMD_INSERT, 63, 32'h1,        32'h0,        1, 0, 0, 0, 0, 5);
		add_row(CMD_GET,    63, 32'h0,        32'h0,        1, 0, 0, 0, 0, 5);
		add_row(CMD_SET,    1,  32'hAAAAAAAA, 32'h0,        0, 0, 0, 0, 0, 0);
		add_row(CMD_SET,    63, 32'h55555555, 32'h0,        1, 0, 0, 0, 0, 5);
		add_row(CMD_GET,    1,  32'h0,        32'h0,        0, 0, 0, 0, 0, 0);
		add_row(CMD_FIND,   0,  32'h0,        32'hFFFFFFFF, 0, 0, 0, 0, 0, 0);
		add_row(CMD_FIND,   0,  32'h0,        32'h55555555, 1, 0, 0, 0, 0, 5);
		add_row(CMD_REMOVE, 0,  32'h0,        32'h0,        0, 0, 0, 0, 0, 0);
		add_row(CMD_SORTED, 0,  32'hFFFFFFFF, 32'h0,        0, 0, 0, 0, 0, 0);
		add_row(CMD_UNUSED, 63, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 0, 0, 0, 5);
		add_row(CMD_ERASE,  0,  32'h0,        32'h0,        0, 0, 0, 0, 0, 0);
		add_row(CMD_ERASE,  63, 32'h0,        32'h0,        1, 0, 0, 0, 0, 4);
		add_row(CMD_GET,    0,  32'h0,        32'h0,        0, 0, 0, 0, 0, 0);
		add_row(CMD_REMOVE, 0,  32'hFFFFFFFF, 32'h0,        0, 0, 0, 0, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n])
			issue_command(directed_rows[n].item, directed_rows[n].typed,
				directed_rows[n].want);

		// Random phases: cycle through the idling mixes, grow the list in two of every three
		// phases and shrink it in the third so it both fills up and empties out.
		for (p = 0; p < PHASE_COUNT; p++) begin
			// Hold off until every result is back before switching the mix.
			s_tvalid <= 1'b0;
			while (pending_results.size() != 0)
				@(posedge clk);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++)
				issue_command(make_random_command(p % 3 != 0), 1'b0, none);
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
